FILE: src/psgtnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psgtnm_pkg
// Shared types, register map and volume table of the tone/noise mixer.
// ----------------------------------------------------------------------------
package psgtnm_pkg;

    // Request kinds carried by the input transaction.
    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

    // Configuration port register indexes.
    typedef enum logic {
        CFG_BASE_STEP   = 1'b0,
        CFG_SIGNED_MODE = 1'b1
    } t_cfg_idx;

    localparam int BASE_STEP_W = 24;
    localparam int COUNT_W     = 32;
    localparam int LFSR_W      = 16;
    localparam int SAMPLE_W    = 14;
    // Wide enough for three full-scale volumes at the default volume shift.
    localparam int SUM_W       = 16;

    localparam logic signed [SUM_W-1:0]    SUM_MAX    = 16'sd8191;
    localparam logic signed [SUM_W-1:0]    SUM_MIN    = -16'sd8192;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 14'sh1FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 14'sh2000;

    // Sound register map.
    localparam logic [3:0] REG_NOISE = 4'd6;
    localparam logic [3:0] REG_MIXER = 4'd7;
    localparam logic [3:0] REG_VOL0  = 4'd8;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hFFFF;

    // Logarithmic volume table.
    function automatic logic [7:0] f_level(input logic [3:0] vol);
        logic [7:0] lv;
        begin
            case (vol)
                4'd0:    lv = 8'h00;
                4'd1:    lv = 8'h01;
                4'd2:    lv = 8'h02;
                4'd3:    lv = 8'h03;
                4'd4:    lv = 8'h05;
                4'd5:    lv = 8'h07;
                4'd6:    lv = 8'h0B;
                4'd7:    lv = 8'h0F;
                4'd8:    lv = 8'h16;
                4'd9:    lv = 8'h1F;
                4'd10:   lv = 8'h2D;
                4'd11:   lv = 8'h3F;
                4'd12:   lv = 8'h5A;
                4'd13:   lv = 8'h7F;
                4'd14:   lv = 8'hB4;
                default: lv = 8'hFF;
            endcase
            return lv;
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/psgtnm_phase.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psgtnm_phase
// Phase counter: adds the base step on each tick and drops one period when
// the sum passes the period, flagging the wrap to its owner.
// ----------------------------------------------------------------------------
module psgtnm_phase
    import psgtnm_pkg::*;
#(
    parameter int PER_W = 34
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_tick,
    input  wire logic [BASE_STEP_W-1:0] i_base_step,
    input  wire logic [PER_W-1:0]       i_period,
    output logic                        o_wrap
);

    localparam int CW = (PER_W > COUNT_W + 1) ? PER_W : COUNT_W + 1;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [CW-1:0]      acc;
    logic [CW-1:0]      per_w;
    logic [CW-1:0]      diff;

    always_comb begin
        acc    = CW'(r_count) + CW'(i_base_step);
        per_w  = CW'(i_period);
        diff   = acc - per_w;
        o_wrap = acc > per_w;
        // The stored count wraps modulo 2^32 on very long periods.
        n_count = o_wrap ? diff[COUNT_W-1:0] : acc[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_tick) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: src/psg_tone_noise_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psg_tone_noise_mixer_top
// Three-tone, one-noise sound generator mixed to one signed 14-bit sample.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ---------------------------------
// in        input      i_in_valid/o_in_ready   i_req_type, i_reg_address,
//                                              i_reg_value
// out       output     o_out_valid/i_out_ready o_sample (signed, 14 bits)
// cfg       input      i_cfg_we                i_cfg_addr, i_cfg_wdata
//
// One transaction is accepted per cycle unless the input stalls. A tick steps
// the phase counters, square waves and LFSR and loads the mix snapshot at its
// accept edge; the mix is summed, saturated and registered when it advances.
// A write only updates the sound registers. If the output register is full and
// not taken, a tick in the mix stage holds and the input stalls. Synchronous
// active-low reset clears all but mix data; square waves go high, LFSR all ones.
// ----------------------------------------------------------------------------
module psg_tone_noise_mixer_top
    import psgtnm_pkg::*;
#(
    parameter int PHASE_SHIFT  = 18,
    parameter int VOLUME_SHIFT = 3,
    parameter int NUM_VOICES   = 3
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input channel.
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_req_type,
    input  wire logic [3:0]              i_reg_address,
    input  wire logic [7:0]              i_reg_value,
    // Output channel.
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [SAMPLE_W-1:0]   o_sample,
    // Configuration write port.
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_addr,
    input  wire logic [BASE_STEP_W-1:0]  i_cfg_wdata
);

    localparam int TPER_W = 16 + PHASE_SHIFT;
    localparam int VOL_W  = 8 + VOLUME_SHIFT;

    // Configuration registers.
    logic [BASE_STEP_W-1:0] r_base_step;
    logic                   r_signed_mode;

    // Sound registers. Only the bits that affect the mix are kept.
    logic [7:0]         r_per_lo    [NUM_VOICES];
    logic [7:0]         r_per_hi    [NUM_VOICES];
    logic [3:0]         r_vol       [NUM_VOICES];
    logic               r_tone_dis  [NUM_VOICES];
    logic               r_noise_dis [NUM_VOICES];
    logic [COUNT_W-1:0] r_noise_step;
    logic [COUNT_W-1:0] n_noise_step;

    // Waveform state.
    logic               r_tone_level [NUM_VOICES];
    logic               n_tone_level [NUM_VOICES];
    logic               tone_wrap    [NUM_VOICES];
    logic [LFSR_W-1:0]  r_lfsr;
    logic [LFSR_W-1:0]  n_lfsr;
    logic               noise_wrap;

    // Mix stage snapshot.
    logic               r_s1_vld;
    logic               r_s1_level [NUM_VOICES];
    logic               r_s1_ton   [NUM_VOICES];
    logic               r_s1_non   [NUM_VOICES];
    logic [VOL_W-1:0]   r_s1_vol   [NUM_VOICES];
    logic               r_s1_nbit;
    logic               r_s1_smode;

    // Output register.
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic signed [SUM_W-1:0]    sum;

    logic in_acc;
    logic tick;
    logic wr;
    logic s1_adv;

    // ------------------------------------------------------------------
    // Flow control.
    // ------------------------------------------------------------------
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign tick       = in_acc && (i_req_type == REQ_TICK);
    assign wr         = in_acc && (i_req_type == REQ_WRITE);

    assign o_out_valid = r_out_vld;
    assign o_sample    = r_sample;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step   <= '0;
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BASE_STEP:   r_base_step   <= i_cfg_wdata;
                CFG_SIGNED_MODE: r_signed_mode <= i_cfg_wdata[0];
                default:         r_base_step   <= r_base_step;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Noise period and LFSR. The noise step is fixed at write time against
    // the base step then in force and is not set below that base step.
    // ------------------------------------------------------------------
    always_comb begin
        n_noise_step = COUNT_W'(i_reg_value[4:0]) << (PHASE_SHIFT + 2);
        if (n_noise_step < COUNT_W'(r_base_step)) begin
            n_noise_step = COUNT_W'(r_base_step);
        end
        n_lfsr = noise_wrap ? {r_lfsr[0] ^ r_lfsr[3], r_lfsr[LFSR_W-1:1]} : r_lfsr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_step <= '0;
            r_lfsr       <= LFSR_SEED;
        end else begin
            if (wr && (i_reg_address == REG_NOISE)) begin
                r_noise_step <= n_noise_step;
            end
            if (tick) begin
                r_lfsr <= n_lfsr;
            end
        end
    end

    psgtnm_phase #(
        .PER_W (COUNT_W)
    ) u_noise_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_base_step (r_base_step),
        .i_period    (r_noise_step),
        .o_wrap      (noise_wrap)
    );

    // ------------------------------------------------------------------
    // Tone voices: period and volume registers, phase counter, square wave
    // and the per-voice part of the mix snapshot.
    // ------------------------------------------------------------------
    for (genvar c = 0; c < NUM_VOICES; c++) begin : g_voice
        psgtnm_phase #(
            .PER_W (TPER_W)
        ) u_tone_phase (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tick      (tick),
            .i_base_step (r_base_step),
            .i_period    ({r_per_hi[c], r_per_lo[c], {PHASE_SHIFT{1'b0}}}),
            .o_wrap      (tone_wrap[c])
        );

        assign n_tone_level[c] = r_tone_level[c] ^ tone_wrap[c];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_per_lo[c]     <= '0;
                r_per_hi[c]     <= '0;
                r_vol[c]        <= '0;
                r_tone_dis[c]   <= 1'b0;
                r_noise_dis[c]  <= 1'b0;
                r_tone_level[c] <= 1'b1;
            end else begin
                if (wr) begin
                    if (i_reg_address == 4'(2 * c)) begin
                        r_per_lo[c] <= i_reg_value;
                    end
                    if (i_reg_address == 4'(2 * c + 1)) begin
                        r_per_hi[c] <= i_reg_value;
                    end
                    if (i_reg_address == REG_VOL0 + 4'(c)) begin
                        r_vol[c] <= i_reg_value[3:0];
                    end
                    if (i_reg_address == REG_MIXER) begin
                        r_tone_dis[c]  <= i_reg_value[c];
                        r_noise_dis[c] <= i_reg_value[c + 3];
                    end
                end
                if (tick) begin
                    r_tone_level[c] <= n_tone_level[c];
                end
            end
        end

        // The mix sees the square wave after this tick's toggle.
        always_ff @(posedge i_clk) begin
            if (tick) begin
                r_s1_level[c] <= n_tone_level[c];
                r_s1_ton[c]   <= !r_tone_dis[c];
                r_s1_non[c]   <= !r_noise_dis[c];
                r_s1_vol[c]   <= VOL_W'(f_level(r_vol[c])) << VOLUME_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_s1_nbit  <= n_lfsr[0];
            r_s1_smode <= r_signed_mode;
        end
    end

    // ------------------------------------------------------------------
    // Mix stage: a voice adds its volume when its enabled tone or noise is
    // high. In signed mode a voice with both sources enabled and both low
    // subtracts its volume instead. The sum saturates to 14 bits.
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [SUM_W-1:0] v;
        sum = '0;
        for (int c = 0; c < NUM_VOICES; c++) begin
            v = SUM_W'(r_s1_vol[c]);
            if ((r_s1_ton[c] && r_s1_level[c]) || (r_s1_non[c] && r_s1_nbit)) begin
                sum = sum + v;
            end else if (r_s1_ton[c] && r_s1_non[c] && r_s1_smode) begin
                sum = sum - v;
            end
        end
        if (sum > SUM_MAX) begin
            n_sample = SAMPLE_MAX;
        end else if (sum < SUM_MIN) begin
            n_sample = SAMPLE_MIN;
        end else begin
            n_sample = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (tick) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_sample <= n_sample;
        end
    end

endmodule
`default_nettype wire
